// ===== design/mtf_pkg.sv =====
package mtf_pkg;

  localparam int ID_W        = 12;
  localparam int POS_W       = 6;
  localparam int CNT_OUT_W   = 7;
  localparam int CMD_W       = 2;
  localparam int STAT_W      = 2;
  localparam int DEPTH_DEF   = 30;
  localparam int ID_BITS_DEF = 12;

  localparam logic [CMD_W-1:0] CMD_TOUCH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic             we;
    logic [POS_W-1:0] waddr;
    logic [ID_W-1:0]  wdata;
    logic             re;
    logic [POS_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic                 was_present;
    logic [POS_W-1:0]     old_position;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 evicted;
    logic [ID_W-1:0]      evicted_id;
    logic [ID_W-1:0]      read_id;
  } res_t;

endpackage

// ===== design/mtf_ram.sv =====
module mtf_ram import mtf_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int W     = ID_BITS_DEF
) (
  input  logic            clk,
  input  mem_req_t        req,
  output logic [ID_W-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata[W-1:0];
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr[AW-1:0]];
    end
  end

  assign rdata = ID_W'(rdata_r);

endmodule

// ===== design/mtf_ctrl.sv =====
module mtf_ctrl import mtf_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [ID_W-1:0]  in_item_id,
  input  logic             in_start_new,
  input  logic [POS_W-1:0] in_position,
  output mem_req_t         mem_req,
  input  logic [ID_W-1:0]  rd_data,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDW   = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam logic [ID_W-1:0]  ID_MASK = ID_W'((64'd1 << IDW) - 64'd1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_WALK = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic             rv_r, rv_nxt;
  logic [CNT_W-1:0] wp_r, wp_nxt;
  logic [ID_W-1:0]  carry_r, carry_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic             found_r, found_nxt;
  logic [POS_W-1:0] oldpos_r, oldpos_nxt;
  res_t             res_r, res_nxt;

  logic [ID_W-1:0]  id_in;
  logic [CNT_W-1:0] load_base;
  logic [CNT_W-1:0] di;

  assign id_in     = in_item_id & ID_MASK;
  assign load_base = in_start_new ? '0 : cnt_r;
  assign di        = i_r - CNT_W'(1);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res       = res_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    i_nxt      = i_r;
    rv_nxt     = 1'b0;
    wp_nxt     = wp_r;
    carry_nxt  = carry_r;
    id_nxt     = id_r;
    found_nxt  = found_r;
    oldpos_nxt = oldpos_r;
    res_nxt    = res_r;
    mem_req    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt             = '0;
          res_nxt.status      = STAT_OK;
          res_nxt.entry_count = CNT_OUT_W'(cnt_r);
          unique case (in_cmd)
            CMD_TOUCH: begin
              id_nxt     = id_in;
              carry_nxt  = id_in;
              wp_nxt     = '0;
              found_nxt  = 1'b0;
              oldpos_nxt = '0;
              i_nxt      = '0;
              if (cnt_r != '0) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = '0;
                i_nxt         = CNT_W'(1);
                rv_nxt        = 1'b1;
              end
              state_nxt = S_WALK;
            end
            CMD_LOAD: begin
              if (load_base < DEPTH_C) begin
                mem_req.we          = 1'b1;
                mem_req.waddr       = POS_W'(load_base);
                mem_req.wdata       = id_in;
                cnt_nxt             = load_base + CNT_W'(1);
                res_nxt.entry_count = CNT_OUT_W'(load_base + CNT_W'(1));
              end else begin
                res_nxt.status = STAT_FULL;
              end
              state_nxt = S_FIN;
            end
            CMD_READ: begin
              if (CNT_OUT_W'(in_position) < CNT_OUT_W'(cnt_r)) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = in_position;
                state_nxt     = S_RD;
              end else begin
                res_nxt.status = STAT_RANGE;
                state_nxt      = S_FIN;
              end
            end
            CMD_NOP: begin
              state_nxt = S_FIN;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_RD: begin
        res_nxt.read_id = rd_data;
        state_nxt       = S_FIN;
      end

      // Reads run one entry ahead; each surviving entry is carried and written
      // back at the write pointer, which never overtakes the read pointer.
      S_WALK: begin
        if (i_r < cnt_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = POS_W'(i_r);
          i_nxt         = i_r + CNT_W'(1);
          rv_nxt        = 1'b1;
        end
        if (rv_r) begin
          if (rd_data == id_r) begin
            if (!found_r) begin
              found_nxt  = 1'b1;
              oldpos_nxt = POS_W'(di);
            end
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = POS_W'(wp_r);
            mem_req.wdata = carry_r;
            wp_nxt        = wp_r + CNT_W'(1);
            carry_nxt     = rd_data;
          end
        end else if (i_r >= cnt_r) begin
          res_nxt.was_present  = found_r;
          res_nxt.old_position = oldpos_r;
          if (wp_r < DEPTH_C) begin
            mem_req.we          = 1'b1;
            mem_req.waddr       = POS_W'(wp_r);
            mem_req.wdata       = carry_r;
            cnt_nxt             = wp_r + CNT_W'(1);
            res_nxt.entry_count = CNT_OUT_W'(wp_r + CNT_W'(1));
          end else begin
            // The carried value is the old tail, and it falls off.
            res_nxt.evicted     = 1'b1;
            res_nxt.evicted_id  = carry_r;
            cnt_nxt             = DEPTH_C;
            res_nxt.entry_count = CNT_OUT_W'(DEPTH_C);
          end
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rv_r    <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    wp_r     <= wp_nxt;
    carry_r  <= carry_nxt;
    id_r     <= id_nxt;
    found_r  <= found_nxt;
    oldpos_r <= oldpos_nxt;
    res_r    <= res_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count exceeds depth");

  a_write_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && rv_r) |-> (wp_r < i_r))
    else $error("compaction write pointer overtook the read pointer");

  a_no_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("read and write to the same entry in one cycle");

  a_fin_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_valid) |-> ($past(state_r) == S_IDLE || $past(state_r) == S_RD ||
                          $past(state_r) == S_WALK))
    else $error("result raised without a command in progress");

endmodule

// ===== design/move_to_front_recent_list_top.sv =====
// Most-recently-used list of item identifiers with move-to-front on touch.
// Input channel (in_valid/in_ready) carries one command item: touch, load
// append, read at position, or no operation. Output channel
// (out_valid/out_ready) returns exactly one result item per command.
// The list lives in a single-port-write, single-port-read memory with a
// registered read. A touch walks the current entries once, reading one
// entry per cycle and writing the survivors back closed up behind the
// touched item, which goes to the front. One command is worked on at a
// time; in_ready is high only while no command is in progress, so the
// next command is accepted in the cycle after the result reaches the
// output register.
// The result sits in an output register, so a new command is accepted while
// an earlier result waits for out_ready; if the receiver still stalls when
// the new result is ready, it is held and in_ready stays low.
// Reset empties the list (count zero) and drops any pending result; the
// memory contents are not cleared and need no clearing pass.
module move_to_front_recent_list_top import mtf_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [ID_W-1:0]      in_item_id,
  input  logic                 in_start_new,
  input  logic [POS_W-1:0]     in_position,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    out_status,
  output logic                 out_was_present,
  output logic [POS_W-1:0]     out_old_position,
  output logic [CNT_OUT_W-1:0] out_entry_count,
  output logic                 out_evicted,
  output logic [ID_W-1:0]      out_evicted_id,
  output logic [ID_W-1:0]      out_read_id
);

  localparam int IDW = (ID_BITS < ID_W) ? ID_BITS : ID_W;

  mem_req_t        mem_req;
  logic [ID_W-1:0] rd_data;
  logic            res_valid;
  logic            res_ready;
  res_t            res;

  logic            out_valid_r;
  res_t            out_res_r;

  mtf_ctrl #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_item_id   (in_item_id),
    .in_start_new (in_start_new),
    .in_position  (in_position),
    .mem_req      (mem_req),
    .rd_data      (rd_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  mtf_ram #(
    .DEPTH (DEPTH),
    .W     (IDW)
  ) u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rd_data)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_was_present  = out_res_r.was_present;
  assign out_old_position = out_res_r.old_position;
  assign out_entry_count  = out_res_r.entry_count;
  assign out_evicted      = out_res_r.evicted;
  assign out_evicted_id   = out_res_r.evicted_id;
  assign out_read_id      = out_res_r.read_id;

endmodule

// ===== tb/mru_list_checker.sv =====
`timescale 1ns / 1ps

module mru_list_checker import mtf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [ID_W-1:0]      in_item_id,
  input  logic                 in_start_new,
  input  logic [POS_W-1:0]     in_position,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [STAT_W-1:0]    out_status,
  input  logic                 out_was_present,
  input  logic [POS_W-1:0]     out_old_position,
  input  logic [CNT_OUT_W-1:0] out_entry_count,
  input  logic                 out_evicted,
  input  logic [ID_W-1:0]      out_evicted_id,
  input  logic [ID_W-1:0]      out_read_id,
  output int                   n_pending,
  output int                   n_errors
);

  localparam int              LIST_DEPTH = DEPTH_DEF;
  localparam logic [ID_W-1:0] ID_MASK    = {ID_W{1'b1}} >> (ID_W - ID_BITS_DEF);

  logic [ID_W-1:0] mru_ids [LIST_DEPTH];
  int              mru_len;
  res_t            want_q [$];

  // Applies one command to the shadow list and returns the result it should give.
  function automatic res_t mru_apply(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] raw_id,
                                     logic start_new, logic [POS_W-1:0] pos);
    res_t            r;
    logic [ID_W-1:0] id;
    int              w;
    r  = '0;
    id = raw_id & ID_MASK;
    if (mru_len > LIST_DEPTH) mru_len = LIST_DEPTH;
    case (cmd)
      CMD_TOUCH: begin
        // Every copy of the item goes; the survivors close up in order.
        w = 0;
        for (int i = 0; i < mru_len; i++) begin
          if (mru_ids[i] == id) begin
            if (!r.was_present) begin
              r.was_present  = 1'b1;
              r.old_position = POS_W'(i);
            end
          end else begin
            mru_ids[w] = mru_ids[i];
            w++;
          end
        end
        mru_len = w;
        if (mru_len == LIST_DEPTH) begin
          r.evicted    = 1'b1;
          r.evicted_id = mru_ids[LIST_DEPTH-1];
          mru_len      = LIST_DEPTH - 1;
        end
        for (int i = mru_len; i > 0; i--) mru_ids[i] = mru_ids[i-1];
        mru_ids[0] = id;
        mru_len++;
      end
      CMD_LOAD: begin
        if (start_new) mru_len = 0;
        if (mru_len < LIST_DEPTH) begin
          mru_ids[mru_len] = id;
          mru_len++;
        end else begin
          r.status = STAT_FULL;
        end
      end
      CMD_READ: begin
        if (pos < mru_len) r.read_id = mru_ids[pos];
        else               r.status  = STAT_RANGE;
      end
      default: ;
    endcase
    r.entry_count = CNT_OUT_W'(mru_len);
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      want_q.delete();
      mru_len = 0;
      n_errors = 0;
      n_pending <= 0;
    end else begin
      // Results are checked before the new item is predicted, as a result
      // accepted at this edge always belongs to an earlier item.
      if (out_valid && out_ready) begin
        got = '{status: out_status, was_present: out_was_present,
                old_position: out_old_position, entry_count: out_entry_count,
                evicted: out_evicted, evicted_id: out_evicted_id, read_id: out_read_id};
        if (want_q.size() == 0) begin
          $error("result item arrived with no prediction waiting");
          n_errors++;
        end else begin
          want = want_q.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            n_errors++;
          end
          if (got.was_present !== want.was_present) begin
            $error("was_present: expected %0d, got %0d", want.was_present, got.was_present);
            n_errors++;
          end
          if (got.old_position !== want.old_position) begin
            $error("old_position: expected %0d, got %0d", want.old_position,
                   got.old_position);
            n_errors++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            n_errors++;
          end
          if (got.evicted !== want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
            n_errors++;
          end
          if (got.evicted_id !== want.evicted_id) begin
            $error("evicted_id: expected %0d, got %0d", want.evicted_id, got.evicted_id);
            n_errors++;
          end
          if (got.read_id !== want.read_id) begin
            $error("read_id: expected %0d, got %0d", want.read_id, got.read_id);
            n_errors++;
          end
        end
      end
      if (in_valid && in_ready)
        want_q.insert(want_q.size(),
                      mru_apply(in_cmd, in_item_id, in_start_new, in_position));
      n_pending <= want_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb import mtf_pkg::*; ();

  localparam int STALL_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 410;

  typedef enum int {RUN_TOUCH, RUN_LOAD, RUN_READ, RUN_MIXED, RUN_NOISE} run_kind_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_cmd;
  logic [ID_W-1:0]      in_item_id;
  logic                 in_start_new;
  logic [POS_W-1:0]     in_position;
  logic                 out_valid;
  logic                 out_ready;
  logic [STAT_W-1:0]    out_status;
  logic                 out_was_present;
  logic [POS_W-1:0]     out_old_position;
  logic [CNT_OUT_W-1:0] out_entry_count;
  logic                 out_evicted;
  logic [ID_W-1:0]      out_evicted_id;
  logic [ID_W-1:0]      out_read_id;

  int n_pending;
  int n_errors;
  int tx_idle_pct;
  int rx_idle_pct;
  int stall_cnt;

  move_to_front_recent_list_top u_top (.*);

  mru_list_checker u_checker (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                          input logic start_new, input logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_item_id   <= id;
    in_start_new <= start_new;
    in_position  <= pos;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_cmd(CMD_READ,  12'd0,    1'b0, 6'd0);
    send_cmd(CMD_TOUCH, 12'd0,    1'b1, 6'd63);
    send_cmd(CMD_TOUCH, 12'hFFF,  1'b0, 6'd0);
    send_cmd(CMD_TOUCH, 12'd0,    1'b0, 6'd0);
    send_cmd(CMD_READ,  12'hFFF,  1'b0, 6'd0);
    send_cmd(CMD_READ,  12'd0,    1'b0, 6'd1);
    send_cmd(CMD_READ,  12'd0,    1'b1, 6'd2);
    send_cmd(CMD_READ,  12'd0,    1'b0, 6'd63);
    send_cmd(CMD_NOP,   12'hFFF,  1'b1, 6'd63);
    send_cmd(CMD_LOAD,  12'hAAA,  1'b1, 6'd0);
    send_cmd(CMD_LOAD,  12'h555,  1'b0, 6'd63);
    send_cmd(CMD_LOAD,  12'hAAA,  1'b0, 6'd0);
    send_cmd(CMD_LOAD,  12'hFFF,  1'b0, 6'd0);
    // Both copies of the duplicated item must go, reporting the first.
    send_cmd(CMD_TOUCH, 12'hAAA,  1'b0, 6'd0);
    send_cmd(CMD_READ,  12'd0,    1'b0, 6'd1);
    send_cmd(CMD_READ,  12'd0,    1'b0, 6'd2);
    send_cmd(CMD_READ,  12'd0,    1'b0, 6'd3);
    send_cmd(CMD_TOUCH, 12'h123,  1'b0, 6'd0);
    send_cmd(CMD_TOUCH, 12'hFFF,  1'b0, 6'd0);
    send_cmd(CMD_NOP,   12'd0,    1'b0, 6'd0);
    send_cmd(CMD_LOAD,  12'd0,    1'b1, 6'd0);
    send_cmd(CMD_READ,  12'd0,    1'b0, 6'd0);
    send_cmd(CMD_LOAD,  12'd0,    1'b0, 6'd0);
    send_cmd(CMD_TOUCH, 12'd0,    1'b0, 6'd0);
  endtask

  // Runs of one run kind each over a mostly small ID pool, so that
  // the list fills, hits repeat, and touches on a full list evict its tail.
  task automatic run_random(input int n_items);
    int               sent;
    int               len;
    int               pick;
    int               pool_sz;
    run_kind_t        kind;
    logic [ID_W-1:0]  pool_base;
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    logic             start_new;
    logic [POS_W-1:0] pos;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if      (pick < 35) kind = RUN_TOUCH;
      else if (pick < 55) kind = RUN_LOAD;
      else if (pick < 70) kind = RUN_READ;
      else if (pick < 90) kind = RUN_MIXED;
      else                kind = RUN_NOISE;
      case ($urandom_range(0, 3))
        0:       pool_sz = 4;
        1:       pool_sz = 16;
        2:       pool_sz = 40;
        default: pool_sz = 4096;
      endcase
      pool_base = ID_W'($urandom);
      len = $urandom_range(4, 40);
      for (int k = 0; k < len; k++) begin
        id        = pool_base + ID_W'($urandom_range(0, pool_sz - 1));
        start_new = 1'($urandom_range(0, 1));
        pos       = POS_W'($urandom);
        case (kind)
          RUN_TOUCH: cmd = CMD_TOUCH;
          RUN_LOAD: begin
            cmd = CMD_LOAD;
            if (k != 0) start_new = ($urandom_range(0, 19) == 0);
          end
          RUN_READ: begin
            cmd = CMD_READ;
            if ($urandom_range(0, 4) != 0) pos = POS_W'($urandom_range(0, 31));
          end
          RUN_MIXED: begin
            cmd = ($urandom_range(0, 2) == 0) ? CMD_READ : CMD_TOUCH;
            if ($urandom_range(0, 3) != 0) pos = POS_W'($urandom_range(0, 31));
          end
          default: begin
            cmd = CMD_W'($urandom);
            id  = ID_W'($urandom);
          end
        endcase
        send_cmd(cmd, id, start_new, pos);
      end
      sent += len;
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_cmd       = CMD_NOP;
    in_item_id   = '0;
    in_start_new = 1'b0;
    in_position  = '0;
    tx_idle_pct  = 23;
    rx_idle_pct  = 79;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    tx_idle_pct = 79;
    rx_idle_pct = 23;
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    // Any stray result would show up within one full touch walk.
    repeat (DEPTH_DEF + 10) @(posedge clk);
    if (n_errors == 0 && n_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mtf_pkg.sv
design/mtf_ram.sv
design/mtf_ctrl.sv
design/move_to_front_recent_list_top.sv
tb/mru_list_checker.sv
tb/tb.sv
